// ===== rtl/nixie_four_tube_scan_driver_top_macros.svh =====
// Assertion macros for the nixie four-tube scan driver.
// Depends on signals named clk and rst_n in the including module.
`ifndef NIXIE_FOUR_TUBE_SCAN_DRIVER_TOP_MACROS_SVH
`define NIXIE_FOUR_TUBE_SCAN_DRIVER_TOP_MACROS_SVH

// When the antecedent holds, the consequent holds in the same cycle.
`define NFTSD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define NFTSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nftsd_pkg.sv =====
// Package of the nixie four-tube scan driver: types, register codes,
// reset values and the decimal split helpers. Depends on nothing.
package nftsd_pkg;

    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ON_TICKS       = 3'd0,
        REG_BLANK_TICKS    = 3'd1,
        REG_SWEEP_PERIOD   = 3'd2,
        REG_SWEEP_FRAMES   = 3'd3,
        REG_PREVIEW_SECOND = 3'd4
    } cfg_reg_t;

    localparam logic [3:0]  ON_TICKS_RST       = 4'd2;
    localparam logic [3:0]  BLANK_TICKS_RST    = 4'd1;
    localparam logic [15:0] SWEEP_PERIOD_RST   = 16'd200;
    localparam logic [7:0]  SWEEP_FRAMES_RST   = 8'd15;
    localparam logic [5:0]  PREVIEW_SECOND_RST = 6'd55;
    localparam logic [3:0]  LAST_SWEEP_DIGIT   = 4'd9;

    typedef logic [3:0] bcd_t;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [30:0] epoch_seconds;
    } tick_t;

    typedef struct packed {
        logic [3:0] bcd_digit;
        logic [1:0] tube_index;
        logic       anode_on;
        logic       colon_on;
        logic       sweeping;
    } result_t;

    // What one frame-start sample of the clock time produces.
    typedef struct packed {
        bcd_t [3:0]  digits;
        logic        even;
        logic        due;
        logic [31:0] next_sweep_time;
    } sample_t;

    // Tens of a value below 64, by multiplication with a reciprocal.
    function automatic logic [2:0] div10(input logic [5:0] v);
        logic [13:0] p;
        p = {8'd0, v} * 14'd205;
        return p[13:11];
    endfunction

    function automatic bcd_t mod10(input logic [5:0] v);
        logic [5:0] t;
        t = {3'd0, div10(v)} * 6'd10;
        return 4'(v - t);
    endfunction

endpackage

// ===== rtl/nftsd_if.sv =====
// Handshake channels of the nixie four-tube scan driver: scan ticks in,
// scan results out, and configuration writes. Depends on nothing.
interface nftsd_tick_if;
    logic        valid;
    logic        ready;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [30:0] epoch_seconds;

    modport source (output valid, hour, minute, second, epoch_seconds, input ready);
    modport sink   (input valid, hour, minute, second, epoch_seconds, output ready);
endinterface

interface nftsd_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] bcd_digit;
    logic [1:0] tube_index;
    logic       anode_on;
    logic       colon_on;
    logic       sweeping;

    modport source (output valid, bcd_digit, tube_index, anode_on, colon_on, sweeping,
                    input ready);
    modport sink   (input valid, bcd_digit, tube_index, anode_on, colon_on, sweeping,
                    output ready);
endinterface

interface nftsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/nftsd_sample.sv =====
// Frame-start time sample: BCD split of the shown fields, colon parity and
// the sweep schedule check. Depends on nftsd_pkg.
module nftsd_sample (
    input  nftsd_pkg::tick_t   tick_item,
    input  logic [5:0]         preview_second,
    input  logic [15:0]        sweep_period_s,
    input  logic [31:0]        next_sweep_time,
    input  logic               sweep_armed,
    output nftsd_pkg::sample_t smp
);
    import nftsd_pkg::*;

    logic        preview;
    logic [5:0]  left;
    logic [5:0]  right;
    logic [31:0] epoch_ext;
    logic [31:0] armed_base;
    logic [31:0] armed_second;
    logic [31:0] sched;

    assign preview = tick_item.second >= preview_second;
    assign left    = preview ? tick_item.minute : {1'b0, tick_item.hour};
    assign right   = preview ? tick_item.second : tick_item.minute;

    assign smp.digits[0] = {1'b0, div10(left)};
    assign smp.digits[1] = mod10(left);
    assign smp.digits[2] = {1'b0, div10(right)};
    assign smp.digits[3] = mod10(right);
    assign smp.even      = ~tick_item.second[0];

    // The first sample arms the schedule one period ahead; both possible
    // follow-on times are formed in parallel so no add feeds another add.
    assign epoch_ext    = {1'b0, tick_item.epoch_seconds};
    assign armed_base   = epoch_ext + {16'd0, sweep_period_s};
    assign armed_second = epoch_ext + {15'd0, sweep_period_s, 1'b0};
    assign sched        = sweep_armed ? next_sweep_time : armed_base;
    assign smp.due      = sched == epoch_ext;

    assign smp.next_sweep_time = !smp.due    ? sched
                               : sweep_armed ? next_sweep_time + {16'd0, sweep_period_s}
                                             : armed_second;

endmodule

// ===== rtl/nixie_four_tube_scan_driver_top.sv =====
// Top level of the nixie four-tube scan driver: tick input register, scan
// state, result register. Depends on nftsd_pkg, nftsd_if.sv, nftsd_sample.
//
// Usage. The tick channel carries one scan tick per transfer, with the
// current hour, minute, second and epoch second. Every tick yields exactly
// one transfer on the result channel: the BCD digit, the tube index, the
// anode enable, the colon and the sweep flag for that tick. The cfg channel
// writes one register per transfer (index 0 on_ticks, 1 blank_ticks,
// 2 sweep_period_s, 3 sweep_frames, 4 preview_second); it is always ready,
// and writes to other indexes are dropped. Write it only while no tick is
// in flight.
// A tick passes the tick register, then the result register. Throughput is
// one tick per cycle while the receiver is ready: the tick register feeds a
// single pass of logic into the result register, so a new tick is taken in
// the same cycle an older result leaves, and the scan state advances once
// per tick. When the receiver stalls, the result register holds its item
// and the tick register takes one more tick before tick.ready drops.
// Reset clears the scan position, the digits, the colon, the sweep state
// and the schedule, and loads the registers with their default values.
// The first frame start after reset arms the sweep schedule.
`include "nixie_four_tube_scan_driver_top_macros.svh"

module nixie_four_tube_scan_driver_top (
    input  logic           clk,
    input  logic           rst_n,
    nftsd_tick_if.sink     tick,
    nftsd_result_if.source result,
    nftsd_cfg_if.sink      cfg
);
    import nftsd_pkg::*;

    // Configuration registers.
    logic [3:0]  on_ticks_reg;
    logic [3:0]  blank_ticks_reg;
    logic [15:0] sweep_period_reg;
    logic [7:0]  sweep_frames_reg;
    logic [5:0]  preview_second_reg;

    // Pipeline registers.
    logic    in_valid_reg;
    tick_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_item_reg;
    logic    advance;

    // Scan state and its next values.
    logic [1:0]  tube_reg,        tube_next;
    logic [3:0]  phase_reg,       phase_next;
    logic        gap_reg,         gap_next;
    bcd_t [3:0]  digits_reg,      digits_next;
    logic        colon_reg,       colon_next;
    logic        sweep_reg,       sweep_next;
    bcd_t        sweep_digit_reg, sweep_digit_next;
    logic [7:0]  sweep_count_reg, sweep_count_next;
    logic [31:0] next_sweep_reg,  next_sweep_next;
    logic        armed_reg,       armed_next;
    logic        pending_reg,     pending_next;
    logic        hold_reg,        hold_next;

    sample_t     smp;
    result_t     res;
    logic        frame_start;
    logic        step_tube;
    logic [3:0]  phase_inc;
    logic [3:0]  lit_ticks;
    logic [7:0]  frames;
    logic [7:0]  count_inc;

    // The configuration port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg       <= ON_TICKS_RST;
            blank_ticks_reg    <= BLANK_TICKS_RST;
            sweep_period_reg   <= SWEEP_PERIOD_RST;
            sweep_frames_reg   <= SWEEP_FRAMES_RST;
            preview_second_reg <= PREVIEW_SECOND_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_ON_TICKS)       on_ticks_reg       <= cfg.data[3:0];
            if (cfg.index == REG_BLANK_TICKS)    blank_ticks_reg    <= cfg.data[3:0];
            if (cfg.index == REG_SWEEP_PERIOD)   sweep_period_reg   <= cfg.data;
            if (cfg.index == REG_SWEEP_FRAMES)   sweep_frames_reg   <= cfg.data[7:0];
            if (cfg.index == REG_PREVIEW_SECOND) preview_second_reg <= cfg.data[5:0];
        end
    end

    // A held tick moves on whenever the result register is empty or is
    // being emptied in this cycle.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_item_reg.hour          <= tick.hour;
            in_item_reg.minute        <= tick.minute;
            in_item_reg.second        <= tick.second;
            in_item_reg.epoch_seconds <= tick.epoch_seconds;
        end
        if (advance)
        begin
            out_item_reg <= res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.bcd_digit  = out_item_reg.bcd_digit;
    assign result.tube_index = out_item_reg.tube_index;
    assign result.anode_on   = out_item_reg.anode_on;
    assign result.colon_on   = out_item_reg.colon_on;
    assign result.sweeping   = out_item_reg.sweeping;

    nftsd_sample u_sample (
        .tick_item       (in_item_reg),
        .preview_second  (preview_second_reg),
        .sweep_period_s  (sweep_period_reg),
        .next_sweep_time (next_sweep_reg),
        .sweep_armed     (armed_reg),
        .smp             (smp)
    );

    // A zero lit time or a zero frame count behaves as one.
    assign lit_ticks   = (on_ticks_reg == 4'd0) ? 4'd1 : on_ticks_reg;
    assign frames      = (sweep_frames_reg == 8'd0) ? 8'd1 : sweep_frames_reg;
    assign phase_inc   = phase_reg + 4'd1;
    assign frame_start = (tube_reg == 2'd0) && (phase_reg == 4'd0) && !gap_reg && !sweep_reg;

    always_comb
    begin
        tube_next        = tube_reg;
        phase_next       = phase_reg;
        gap_next         = gap_reg;
        digits_next      = digits_reg;
        colon_next       = colon_reg;
        sweep_next       = sweep_reg;
        sweep_digit_next = sweep_digit_reg;
        sweep_count_next = sweep_count_reg;
        next_sweep_next  = next_sweep_reg;
        armed_next       = armed_reg;
        pending_next     = pending_reg;
        hold_next        = hold_reg;
        step_tube        = 1'b0;
        count_inc        = sweep_count_reg + 8'd1;

        // Frame start: sample the time, unless this is the single frame
        // after a sweep, which reuses the time sampled before the sweep.
        if (frame_start)
        begin
            if (hold_reg)
            begin
                hold_next = 1'b0;
            end
            else
            begin
                digits_next     = smp.digits;
                next_sweep_next = smp.next_sweep_time;
                armed_next      = 1'b1;
                if (smp.due)
                begin
                    sweep_next       = 1'b1;
                    sweep_digit_next = 4'd0;
                    sweep_count_next = 8'd0;
                    pending_next     = smp.even;
                    hold_next        = 1'b1;
                end
                else
                begin
                    colon_next = smp.even;
                end
            end
        end

        // The result reflects the sample but not the phase step below.
        res.bcd_digit  = sweep_next ? sweep_digit_next : digits_next[tube_reg];
        res.tube_index = tube_reg;
        res.anode_on   = !gap_reg;
        res.colon_on   = colon_next;
        res.sweeping   = sweep_next;

        if (!gap_reg)
        begin
            if (phase_inc >= lit_ticks)
            begin
                phase_next = 4'd0;
                if (blank_ticks_reg != 4'd0)
                begin
                    gap_next = 1'b1;
                end
                else
                begin
                    step_tube = 1'b1;
                end
            end
            else
            begin
                phase_next = phase_inc;
            end
        end
        else if (phase_inc >= blank_ticks_reg)
        begin
            phase_next = 4'd0;
            gap_next   = 1'b0;
            step_tube  = 1'b1;
        end
        else
        begin
            phase_next = phase_inc;
        end

        // Wrapping back to the leftmost tube ends a frame; during a sweep
        // that counts frames and steps the sweep digit.
        if (step_tube)
        begin
            tube_next = tube_reg + 2'd1;
            if ((tube_reg == 2'd3) && sweep_next)
            begin
                if (count_inc >= frames)
                begin
                    sweep_count_next = 8'd0;
                    if (sweep_digit_next >= LAST_SWEEP_DIGIT)
                    begin
                        sweep_next       = 1'b0;
                        sweep_digit_next = 4'd0;
                        colon_next       = pending_next;
                    end
                    else
                    begin
                        sweep_digit_next = sweep_digit_next + 4'd1;
                    end
                end
                else
                begin
                    sweep_count_next = count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tube_reg        <= '0;
            phase_reg       <= '0;
            gap_reg         <= 1'b0;
            digits_reg      <= '0;
            colon_reg       <= 1'b0;
            sweep_reg       <= 1'b0;
            sweep_digit_reg <= '0;
            sweep_count_reg <= '0;
            next_sweep_reg  <= '0;
            armed_reg       <= 1'b0;
            pending_reg     <= 1'b0;
            hold_reg        <= 1'b0;
        end
        else if (advance)
        begin
            tube_reg        <= tube_next;
            phase_reg       <= phase_next;
            gap_reg         <= gap_next;
            digits_reg      <= digits_next;
            colon_reg       <= colon_next;
            sweep_reg       <= sweep_next;
            sweep_digit_reg <= sweep_digit_next;
            sweep_count_reg <= sweep_count_next;
            next_sweep_reg  <= next_sweep_next;
            armed_reg       <= armed_next;
            pending_reg     <= pending_next;
            hold_reg        <= hold_next;
        end
    end

    // The sweep digit never passes nine, and is parked at zero outside a sweep.
    `NFTSD_ASSERT_SAME(a_sweep_digit_range, 1'b1, sweep_digit_reg <= LAST_SWEEP_DIGIT, "sweep digit out of range")
    `NFTSD_ASSERT_SAME(a_sweep_idle_parked, !sweep_reg, (sweep_digit_reg == 4'd0) && (sweep_count_reg == 8'd0), "sweep counters not parked")
    // Every offered result carries a decimal digit.
    `NFTSD_ASSERT_SAME(a_result_decimal, out_valid_reg, out_item_reg.bcd_digit <= 4'd9, "result digit not decimal")
    // A started sweep is flagged on the very result of the tick that started it.
    `NFTSD_ASSERT_NEXT(a_sweep_start_flag, advance && frame_start && !hold_reg && smp.due, out_item_reg.sweeping && sweep_reg, "sweep start not flagged")

endmodule
